// File: design/ufcr_pkg.sv
// Shared types and constants for the update frame checker and responder.
`default_nettype none

package ufcr_pkg;

  localparam logic [7:0] HDR_BYTE0 = 8'hA9;
  localparam logic [7:0] HDR_BYTE1 = 8'h54;

  localparam logic [7:0] CMD_CLEAR_SERIAL = 8'hE1;
  localparam logic [7:0] CMD_LOAD_TOTAL   = 8'hE2;
  localparam logic [7:0] CMD_NEXT_PACKET  = 8'hE3;
  localparam logic [7:0] CMD_DONE         = 8'hE4;

  localparam logic [7:0] REPLY_SYNC0 = 8'hAA;
  localparam logic [7:0] REPLY_SYNC1 = 8'h55;
  localparam logic [7:0] REPLY_TYPE  = 8'h02;

  localparam logic [7:0] RPL_ERROR    = 8'h00;
  localparam logic [7:0] RPL_PACK_LEN = 8'h01;
  localparam logic [7:0] RPL_NEXT     = 8'h02;
  localparam logic [7:0] RPL_DONE     = 8'h03;

  // Sum of the reply's sync and type bytes, folded into the checksum base.
  localparam logic [15:0] REPLY_SUM_BASE = 16'h0101;

  localparam int unsigned HEAD_DEPTH     = 9;
  localparam int unsigned FRAME_OVERHEAD = 9;
  localparam int unsigned REPLY_LEN      = 8;
  localparam int unsigned QUEUE_DEPTH    = 4;

  typedef enum logic [2:0] {
    K_ERROR,
    K_PACK_LEN,
    K_LOAD_TOTAL,
    K_NEXT,
    K_DONE
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [15:0] total;
  } cmd_t;

  typedef enum logic {
    B_IDLE,
    B_SEND
  } back_state_e;

endpackage

`default_nettype wire

// File: design/ufcr_if.sv
// Handshake channels for received frame bytes and reply bytes.
`default_nettype none

interface ufcr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_end;

  modport source (output valid, output rx_byte, output frame_end, input ready);
  modport sink (input valid, input rx_byte, input frame_end, output ready);
endinterface

interface ufcr_tx_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       tx_last;

  modport source (output valid, output tx_byte, output tx_last, input ready);
  modport sink (input valid, input tx_byte, input tx_last, output ready);
endinterface

`default_nettype wire

// File: design/update_frame_checker_responder_unit.sv
// Update frame checker and responder, top level.
// Takes one received byte per cycle unless the queue is full; frame_end marks a frame's
// last byte. The front end keeps the byte count, running sum and header bytes and checks
// the frame on its last byte in the same cycle, then posts the resulting command to a
// four-entry queue. The back end runs each command against the serial number and packet
// total and sends its 8-byte reply at one byte per cycle while the output is ready.
// Input ready drops only while the queue is full, so bytes are taken every cycle unless
// more than four replies stand unsent. Frames with a command that has no reply take no
// queue entry.
`default_nettype none

module update_frame_checker_responder_unit
  import ufcr_pkg::*;
#(
  parameter int unsigned MAX_FRAME = 1024
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ufcr_rx_if.sink   rx_i,
  ufcr_tx_if.source tx_o
);

  logic full, empty, push, pop;
  cmd_t push_cmd, pop_cmd;

  ufcr_front #(
    .MaxFrame(MAX_FRAME)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (rx_i.valid),
    .in_byte_i  (rx_i.rx_byte),
    .in_last_i  (rx_i.frame_end),
    .in_ready_o (rx_i.ready),
    .full_i     (full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  ufcr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_cmd),
    .empty_o     (empty)
  );

  ufcr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .cmd_i       (pop_cmd),
    .pop_o       (pop),
    .out_valid_o (tx_o.valid),
    .out_ready_i (tx_o.ready),
    .out_byte_o  (tx_o.tx_byte),
    .out_last_o  (tx_o.tx_last)
  );

endmodule

`default_nettype wire

// File: design/ufcr_front.sv
// Front end: gathers frame bytes, checks the frame and classifies its command.
`default_nettype none

module ufcr_front
  import ufcr_pkg::*;
#(
  parameter int unsigned MaxFrame = 1024
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       in_last_i,
  output logic            in_ready_o,
  input  wire logic       full_i,
  output logic            push_o,
  output cmd_t            cmd_o
);

  localparam int unsigned CntW = $clog2(MaxFrame + 2);
  localparam int unsigned LenW = (CntW > 17) ? CntW : 17;

  logic [CntW-1:0] count_q, count_d, count_upd;
  logic [15:0]     sum_q, sum_d, sum_upd;
  logic [7:0]      tail_q [2];
  logic [7:0]      tail_d [2];
  logic [7:0]      tail_upd [2];
  logic            ovf_q, ovf_d, ovf_upd;
  logic [7:0]      head_q [HEAD_DEPTH];
  logic [7:0]      head_d [HEAD_DEPTH];
  logic            accept;
  logic            ok;
  logic [LenW-1:0] len_ext, field_ext;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;

  always_comb begin
    count_upd   = count_q;
    sum_upd     = sum_q;
    tail_upd[0] = tail_q[0];
    tail_upd[1] = tail_q[1];
    ovf_upd     = ovf_q;
    for (int i = 0; i < HEAD_DEPTH; i++) begin
      head_d[i] = head_q[i];
    end
    if (count_q < CntW'(MaxFrame)) begin
      if (count_q < CntW'(HEAD_DEPTH)) begin
        head_d[count_q[3:0]] = in_byte_i;
      end
      if (count_q >= CntW'(2)) begin
        sum_upd = sum_q + 16'(tail_q[1]);
      end
      tail_upd[1] = tail_q[0];
      tail_upd[0] = in_byte_i;
      count_upd   = count_q + CntW'(1);
    end else begin
      ovf_upd   = 1'b1;
      count_upd = CntW'(MaxFrame + 1);
    end
  end

  assign len_ext   = LenW'(count_upd);
  assign field_ext = LenW'({head_d[2], head_d[3]}) + LenW'(FRAME_OVERHEAD);

  always_comb begin
    ok = !ovf_upd && (count_upd >= CntW'(HEAD_DEPTH));
    if (head_d[0] != HDR_BYTE0 || head_d[1] != HDR_BYTE1) begin
      ok = 1'b0;
    end
    if (field_ext != len_ext) begin
      ok = 1'b0;
    end
    if (sum_upd != {tail_upd[1], tail_upd[0]}) begin
      ok = 1'b0;
    end
  end

  always_comb begin
    cmd_o.total = {head_d[7], head_d[8]};
    cmd_o.kind  = K_ERROR;
    push_o      = accept && in_last_i;
    if (ok) begin
      case (head_d[4])
        CMD_CLEAR_SERIAL: cmd_o.kind = K_PACK_LEN;
        CMD_LOAD_TOTAL:   cmd_o.kind = K_LOAD_TOTAL;
        CMD_NEXT_PACKET:  cmd_o.kind = K_NEXT;
        CMD_DONE:         cmd_o.kind = K_DONE;
        default:          push_o = 1'b0;
      endcase
    end
  end

  always_comb begin
    count_d   = count_upd;
    sum_d     = sum_upd;
    tail_d[0] = tail_upd[0];
    tail_d[1] = tail_upd[1];
    ovf_d     = ovf_upd;
    if (in_last_i) begin
      count_d   = '0;
      sum_d     = '0;
      tail_d[0] = '0;
      tail_d[1] = '0;
      ovf_d     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      sum_q     <= '0;
      tail_q[0] <= '0;
      tail_q[1] <= '0;
      ovf_q     <= 1'b0;
    end else if (accept) begin
      count_q   <= count_d;
      sum_q     <= sum_d;
      tail_q[0] <= tail_d[0];
      tail_q[1] <= tail_d[1];
      ovf_q     <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int i = 0; i < HEAD_DEPTH; i++) begin
        head_q[i] <= head_d[i];
      end
    end
  end

endmodule

`default_nettype wire

// File: design/ufcr_queue.sv
// Short command queue between the front and back ends.
`default_nettype none

module ufcr_queue
  import ufcr_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t push_data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output cmd_t      pop_data_o,
  output logic      empty_o
);

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);

  cmd_t            mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   fill_q;

  assign full_o     = (fill_q == (PtrW + 1)'(QUEUE_DEPTH));
  assign empty_o    = (fill_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + (PtrW + 1)'(1);
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - (PtrW + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// File: design/ufcr_back.sv
// Back end: runs commands against the serial state and sends the reply bytes.
`default_nettype none

module ufcr_back
  import ufcr_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       empty_i,
  input  wire cmd_t       cmd_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            out_last_o
);

  localparam int unsigned IdxW = $clog2(REPLY_LEN);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(REPLY_LEN - 1);

  back_state_e     state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [7:0]      code_q, code_d;
  logic [15:0]     ser_out_q, ser_out_d;
  logic [15:0]     chk_q, chk_d;
  logic [15:0]     serial_q, serial_d;
  logic [15:0]     total_q, total_d;
  logic [15:0]     serial_inc;
  logic            take;

  assign serial_inc  = serial_q + 16'd1;
  assign out_valid_o = (state_q == B_SEND);
  assign out_last_o  = (idx_q == LastIdx);

  always_comb begin
    case (idx_q)
      IdxW'(0): out_byte_o = REPLY_SYNC0;
      IdxW'(1): out_byte_o = REPLY_SYNC1;
      IdxW'(2): out_byte_o = REPLY_TYPE;
      IdxW'(3): out_byte_o = code_q;
      IdxW'(4): out_byte_o = ser_out_q[15:8];
      IdxW'(5): out_byte_o = ser_out_q[7:0];
      IdxW'(6): out_byte_o = chk_q[15:8];
      default:  out_byte_o = chk_q[7:0];
    endcase
  end

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    code_d    = code_q;
    ser_out_d = ser_out_q;
    serial_d  = serial_q;
    total_d   = total_q;
    pop_o     = 1'b0;
    take      = (state_q == B_IDLE) || (out_ready_i && out_last_o);
    if (take) begin
      state_d = B_IDLE;
      if (!empty_i) begin
        pop_o     = 1'b1;
        state_d   = B_SEND;
        idx_d     = '0;
        code_d    = RPL_ERROR;
        ser_out_d = '0;
        case (cmd_i.kind)
          K_PACK_LEN: begin
            code_d   = RPL_PACK_LEN;
            serial_d = '0;
          end
          K_LOAD_TOTAL: begin
            code_d    = RPL_NEXT;
            total_d   = cmd_i.total;
            serial_d  = serial_inc;
            ser_out_d = serial_inc;
          end
          K_NEXT: begin
            if (serial_q <= total_q) begin
              code_d    = RPL_NEXT;
              serial_d  = serial_inc;
              ser_out_d = serial_inc;
            end
          end
          K_DONE: code_d = RPL_DONE;
          default: code_d = RPL_ERROR;
        endcase
      end
    end else if (out_ready_i) begin
      idx_d = idx_q + IdxW'(1);
    end
    chk_d = REPLY_SUM_BASE + 16'(code_d) + 16'(ser_out_d[15:8]) + 16'(ser_out_d[7:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_IDLE;
      idx_q    <= '0;
      serial_q <= '0;
      total_q  <= '0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      serial_q <= serial_d;
      total_q  <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q    <= code_d;
    ser_out_q <= ser_out_d;
    chk_q     <= chk_d;
  end

endmodule

`default_nettype wire

// File: tb/ufcr_reply_checker.sv
// Reply predictor and scoreboard for the update frame checker and responder.
`timescale 1ns / 1ps

module ufcr_reply_checker
  import ufcr_pkg::*;
#(
  parameter int unsigned MAX_FRAME = 1024
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ufcr_rx_if        rx_i,
  ufcr_tx_if        tx_i,
  output int        mismatch_cnt_o,
  output int        pending_cnt_o,
  output int        reply_cnt_o
);

  localparam int unsigned CNT_W = $clog2(MAX_FRAME + 2);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } reply_byte_t;

  logic [CNT_W-1:0] byte_cnt;
  logic [15:0]      body_sum;
  logic [7:0]       head_q [HEAD_DEPTH];
  logic [7:0]       tail_q [2];
  logic             oversize;
  logic [15:0]      serial_q;
  logic [15:0]      total_q;
  reply_byte_t      reply_q [$];
  int               mismatch_cnt = 0;
  int               reply_cnt = 0;

  assign mismatch_cnt_o = mismatch_cnt;
  assign reply_cnt_o    = reply_cnt;

  task automatic queue_reply(input logic [7:0] kind, input logic [15:0] arg);
    logic [7:0]  rb [REPLY_LEN];
    logic [15:0] csum;
    int          k;
    rb[0] = REPLY_SYNC0;
    rb[1] = REPLY_SYNC1;
    rb[2] = REPLY_TYPE;
    rb[3] = kind;
    rb[4] = arg[15:8];
    rb[5] = arg[7:0];
    csum = '0;
    for (k = 0; k < 6; k++) csum = csum + 16'(rb[k]);
    rb[6] = csum[15:8];
    rb[7] = csum[7:0];
    for (k = 0; k < REPLY_LEN; k++) begin
      reply_q.push_back('{data: rb[k], last: (k == REPLY_LEN - 1)});
    end
  endtask

  task automatic queue_next_packet();
    serial_q = serial_q + 16'd1;
    queue_reply(RPL_NEXT, serial_q);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic        good;
    logic [15:0] len_field;
    logic [15:0] trailer;
    logic        orphan;
    reply_byte_t want;
    if (!rst_ni) begin
      byte_cnt = '0;
      body_sum = '0;
      tail_q[0] = '0;
      tail_q[1] = '0;
      oversize = 1'b0;
      serial_q = '0;
      total_q = '0;
      reply_q.delete();
      pending_cnt_o <= 0;
    end else begin
      if (rx_i.valid && rx_i.ready) begin
        if (byte_cnt < MAX_FRAME) begin
          if (byte_cnt < HEAD_DEPTH) head_q[byte_cnt[3:0]] = rx_i.rx_byte;
          if (byte_cnt >= 2) body_sum = body_sum + 16'(tail_q[1]);
          tail_q[1] = tail_q[0];
          tail_q[0] = rx_i.rx_byte;
          byte_cnt = byte_cnt + 1'b1;
        end else begin
          oversize = 1'b1;
          byte_cnt = CNT_W'(MAX_FRAME + 1);
        end
        if (rx_i.frame_end) begin
          trailer = {tail_q[1], tail_q[0]};
          good = !oversize && (byte_cnt >= HEAD_DEPTH);
          if (good) begin
            len_field = {head_q[2], head_q[3]};
            if (head_q[0] != HDR_BYTE0 || head_q[1] != HDR_BYTE1) good = 1'b0;
            if (32'(len_field) + FRAME_OVERHEAD != 32'(byte_cnt)) good = 1'b0;
            if (body_sum != trailer) good = 1'b0;
          end
          byte_cnt = '0;
          body_sum = '0;
          tail_q[0] = '0;
          tail_q[1] = '0;
          oversize = 1'b0;
          if (!good) begin
            queue_reply(RPL_ERROR, '0);
          end else begin
            case (head_q[4])
              CMD_CLEAR_SERIAL: begin
                serial_q = '0;
                queue_reply(RPL_PACK_LEN, '0);
              end
              CMD_LOAD_TOTAL: begin
                total_q = {head_q[7], head_q[8]};
                queue_next_packet();
              end
              CMD_NEXT_PACKET: begin
                if (serial_q <= total_q) queue_next_packet();
                else queue_reply(RPL_ERROR, '0);
              end
              CMD_DONE: begin
                queue_reply(RPL_DONE, '0);
              end
              default: begin
              end
            endcase
          end
        end
      end
      if (tx_i.valid && tx_i.ready) begin
        reply_cnt++;
        orphan = (reply_q.size() == 0);
        if (!orphan) want = reply_q.pop_front();
        if (orphan || want.data !== tx_i.tx_byte || want.last !== tx_i.tx_last) begin
          if (mismatch_cnt < 10) begin
            if (orphan) begin
              $display("%0t: unexpected reply byte %02h last %b", $time,
                       tx_i.tx_byte, tx_i.tx_last);
            end else begin
              $display("%0t: reply byte %02h last %b, expected %02h last %b", $time,
                       tx_i.tx_byte, tx_i.tx_last, want.data, want.last);
            end
          end
          mismatch_cnt++;
        end
      end
      pending_cnt_o <= reply_q.size();
    end
  end

endmodule

// File: tb/update_frame_checker_responder_unit_tb.sv
// Stimulus and verdict for the update frame checker and responder.
`timescale 1ns / 1ps

module update_frame_checker_responder_unit_tb;
  import ufcr_pkg::*;

  localparam int unsigned MAX_FRAME    = 1024;
  localparam int unsigned RANDOM_BYTES = 30;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned TAIL_CYCLES  = 20;

  localparam logic [7:0] CMD_UNKNOWN_LO = 8'h00;
  localparam logic [7:0] CMD_UNKNOWN_HI = 8'hFF;

  typedef logic [7:0] frame_q_t [$];

  typedef enum {
    F_GOOD,
    F_BAD_HEADER,
    F_BAD_LENGTH,
    F_BAD_SUM,
    F_SHORT,
    F_NOISE
  } frame_flaw_e;

  logic clk_i;
  logic rst_ni;
  bit   src_idle;
  bit   snk_idle;
  int   bytes_sent = 0;
  int   frames_sent = 0;
  int   stall_cycles = 0;
  int   mismatch_cnt;
  int   pending_cnt;
  int   reply_cnt;

  ufcr_rx_if rx_ch ();
  ufcr_tx_if tx_ch ();

  update_frame_checker_responder_unit #(
    .MAX_FRAME(MAX_FRAME)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .rx_i  (rx_ch),
    .tx_o  (tx_ch)
  );

  ufcr_reply_checker #(
    .MAX_FRAME(MAX_FRAME)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rx_i          (rx_ch),
    .tx_i          (tx_ch),
    .mismatch_cnt_o(mismatch_cnt),
    .pending_cnt_o (pending_cnt),
    .reply_cnt_o   (reply_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (rx_ch.valid && rx_ch.ready) || (tx_ch.valid && tx_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int stall;
    tx_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = snk_idle ? $urandom_range(0, 4) : 0;
      if (stall != 0) begin
        tx_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      tx_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!tx_ch.valid) @(posedge clk_i);
    end
  end

  task automatic form_frame(input logic [7:0] cmd, input int len, input logic [15:0] tot,
                            input frame_flaw_e flaw, output frame_q_t f);
    logic [15:0] field;
    logic [15:0] csum;
    int          k;
    int          keep;
    f = {};
    if (flaw == F_NOISE) begin
      keep = $urandom_range(1, 20);
      for (k = 0; k < keep; k++) f.push_back(8'($urandom));
      return;
    end
    field = 16'(len - FRAME_OVERHEAD);
    if (flaw == F_BAD_LENGTH) field = field + 16'($urandom_range(1, 65535));
    f.push_back(HDR_BYTE0);
    f.push_back(HDR_BYTE1);
    f.push_back(field[15:8]);
    f.push_back(field[7:0]);
    f.push_back(cmd);
    for (k = 5; k < len - 2; k++) f.push_back(8'($urandom));
    if (len >= 11) begin
      f[7] = tot[15:8];
      f[8] = tot[7:0];
    end
    if (flaw == F_BAD_HEADER) begin
      k = $urandom_range(0, 1);
      f[k] = f[k] ^ 8'($urandom_range(1, 255));
    end
    csum = '0;
    foreach (f[k]) csum = csum + 16'(f[k]);
    f.push_back(csum[15:8]);
    f.push_back(csum[7:0]);
    if (flaw == F_BAD_SUM) begin
      k = f.size() - $urandom_range(1, 2);
      f[k] = f[k] ^ (8'h01 << $urandom_range(0, 7));
    end
    if (flaw == F_SHORT) begin
      keep = $urandom_range(1, HEAD_DEPTH - 1);
      f = f[0:keep-1];
    end
  endtask

  task automatic send_frame(input frame_q_t f);
    int k;
    int gap;
    for (k = 0; k < f.size(); k++) begin
      gap = src_idle ? $urandom_range(0, 4) : 0;
      if (gap != 0) begin
        rx_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      rx_ch.valid     <= 1'b1;
      rx_ch.rx_byte   <= f[k];
      rx_ch.frame_end <= (k == f.size() - 1);
      @(posedge clk_i);
      while (!rx_ch.ready) @(posedge clk_i);
      bytes_sent++;
    end
    frames_sent++;
  endtask

  task automatic send_good(input logic [7:0] cmd, input int len, input logic [15:0] tot);
    frame_q_t f;
    form_frame(cmd, len, tot, F_GOOD, f);
    send_frame(f);
  endtask

  task automatic send_flawed(input frame_flaw_e flaw);
    frame_q_t f;
    form_frame(CMD_DONE, $urandom_range(9, 14), '0, flaw, f);
    send_frame(f);
  endtask

  task automatic drain_replies();
    rx_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
  endtask

  task automatic send_random_frame();
    frame_flaw_e flaw;
    logic [7:0]  cmd;
    logic [15:0] tot;
    int          len;
    frame_q_t    f;
    flaw = ($urandom_range(0, 99) < 70) ? F_GOOD : frame_flaw_e'($urandom_range(1, 5));
    case ($urandom_range(0, 9))
      0:       cmd = CMD_CLEAR_SERIAL;
      1, 2:    cmd = CMD_LOAD_TOTAL;
      3, 4, 5: cmd = CMD_NEXT_PACKET;
      6:       cmd = CMD_DONE;
      default: cmd = 8'($urandom);
    endcase
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(9, 13);
    tot = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
    form_frame(cmd, len, tot, flaw, f);
    send_frame(f);
  endtask

  initial begin
    int random_start;
    rx_ch.valid     = 1'b0;
    rx_ch.rx_byte   = '0;
    rx_ch.frame_end = 1'b0;
    src_idle = 1'b1;
    snk_idle = 1'b1;
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_good(CMD_CLEAR_SERIAL, 9, '0);
    send_good(CMD_LOAD_TOTAL, 11, 16'h0001);
    send_good(CMD_NEXT_PACKET, 9, '0);
    send_good(CMD_NEXT_PACKET, 10, '0);
    send_good(CMD_DONE, 12, '0);
    send_good(CMD_UNKNOWN_LO, 9, '0);
    send_good(CMD_UNKNOWN_HI, 11, 16'hFFFF);
    drain_replies();
    send_flawed(F_BAD_HEADER);
    send_flawed(F_BAD_LENGTH);
    send_flawed(F_BAD_SUM);
    send_flawed(F_SHORT);
    send_frame('{8'hFF});
    send_flawed(F_NOISE);
    send_good(CMD_LOAD_TOTAL, 9, '0);
    send_good(CMD_LOAD_TOTAL, 11, 16'h0000);
    send_good(CMD_NEXT_PACKET, 9, '0);
    drain_replies();

    random_start = bytes_sent;
    while (bytes_sent - random_start < RANDOM_BYTES) begin
      if ($urandom_range(0, 3) == 0) begin
        src_idle = ($urandom_range(0, 3) != 0);
        snk_idle = ($urandom_range(0, 3) != 0);
      end
      send_random_frame();
      if ($urandom_range(0, 9) == 0) drain_replies();
    end
    drain_replies();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Sent %0d frames, %0d bytes: all commands, broken, short and noise frames,",
             frames_sent, bytes_sent);
    $display("random frames under stalls; %0d reply bytes checked, %0d mismatches",
             reply_cnt, mismatch_cnt);
    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
design/ufcr_pkg.sv
design/ufcr_if.sv
design/ufcr_front.sv
design/ufcr_queue.sv
design/ufcr_back.sv
design/update_frame_checker_responder_unit.sv
tb/ufcr_reply_checker.sv
tb/update_frame_checker_responder_unit_tb.sv
